// ===== src/aks_pkg.sv =====
// aks_pkg: shared constants, s-box and gf(2^8) helpers for the aes-128 key schedule
// no dependencies
`default_nettype none
package aks_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumOut    = 22;
  localparam int unsigned RndW      = 4;
  localparam int unsigned CntW      = 5;

  typedef logic [127:0] blk_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // x*9, x*11, x*13, x*14 from x2, x4, x8
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] s [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      s[i]  = c[31-8*i -: 8];
      x2    = xtime(s[i]);
      x4    = xtime(x2);
      x8    = xtime(x4);
      m9[i] = x8 ^ s[i];
      mb[i] = x8 ^ x2 ^ s[i];
      md[i] = x8 ^ x4 ^ s[i];
      me[i] = x8 ^ x4 ^ x2;
    end
    return {me[0]^mb[1]^md[2]^m9[3], m9[0]^me[1]^mb[2]^md[3],
            md[0]^m9[1]^me[2]^mb[3], mb[0]^md[1]^m9[2]^me[3]};
  endfunction

  function automatic blk_t inv_mix(input blk_t b);
    return {inv_mix_col(b[127:96]), inv_mix_col(b[95:64]),
            inv_mix_col(b[63:32]), inv_mix_col(b[31:0])};
  endfunction
endpackage
`default_nettype wire

// ===== src/aes128_key_schedule.sv =====
// aes128_key_schedule: top level, chain of eleven round key cells and output sequencer
// depends on aks_pkg and aks_cell
// A key transfer on key_valid_i/key_ready_o loads a row of eleven cells in a
// cascade: cell 0 takes the key, and in each following cycle cell r takes the
// expansion of cell r-1.
// Every key gives 22 round key transfers: encryption keys 0..10, then the
// equivalent inverse cipher keys 10, invmixcolumns of 9..1, then 0 with last_o.
// One round key leaves per cycle when the sink is ready; the output counter is
// the only limit. After the key transfer, the first round key goes from cell 0
// into the output register once that register is free. The next key is accepted at
// the edge that moves the final round key of the previous one into the output
// register, so the round keys of one key follow those of the last with no gap.
`default_nettype none
module aes128_key_schedule import aks_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        key_valid_i,
  output logic             key_ready_o,
  input  wire logic [63:0] key_high_i,
  input  wire logic [63:0] key_low_i,
  output logic             rk_valid_o,
  input  wire logic        rk_ready_i,
  output logic [3:0]       round_number_o,
  output logic             for_decrypt_o,
  output logic [63:0]      round_key_high_o,
  output logic [63:0]      round_key_low_o,
  output logic             last_o
);
  // the last cell has no successor, so it gets a zero round constant
  localparam logic [7:0] Rcon [NumRounds+1] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                                8'h20, 8'h40, 8'h80, 8'h1b, 8'h36,
                                                8'h00};

  blk_t cell_key [NumRounds+1];
  blk_t cell_nxt [NumRounds+1];
  blk_t cell_in  [NumRounds+1];
  logic [NumRounds:0] load;

  // busy_q: key in progress; idx_q: next result to emit; age_q: chain age since load, stops at NumRounds
  logic            busy_q;
  logic [CntW-1:0] idx_q;
  logic [RndW-1:0] age_q;
  logic            key_xfer, rk_xfer, out_free, issue;

  // output register
  logic            ovld_q;
  logic [RndW-1:0] orn_q;
  logic            odec_q, olast_q;
  blk_t            okey_q;

  // cell 0 takes the key, every other cell the expansion of its neighbor
  always_comb begin
    cell_in[0] = {key_high_i, key_low_i};
    for (int r = 1; r <= NumRounds; r++) begin
      cell_in[r] = cell_nxt[r-1];
    end
  end

  genvar g;
  generate
    for (g = 0; g <= NumRounds; g++) begin : g_cell
      aks_cell u_cell (
        .clk_i (clk_i),
        .load_i(load[g]),
        .rcon_i(Rcon[g]),
        .key_i (cell_in[g]),
        .key_o (cell_key[g]),
        .next_o(cell_nxt[g])
      );
    end
  endgenerate

  // cascade load: cell r loads when the chain age equals r-1
  always_comb begin
    load[0] = key_xfer;
    for (int r = 1; r <= NumRounds; r++) begin
      load[r] = busy_q && (age_q == RndW'(r - 1));
    end
  end

  assign out_free    = !ovld_q || rk_ready_i;
  assign rk_xfer     = rk_valid_o && rk_ready_i;
  // a new key may load cell 0 in the cycle that issues the final round key
  assign key_ready_o = !busy_q || (issue && idx_q == CntW'(NumOut - 1));
  assign key_xfer    = key_valid_i && key_ready_o;

  // result idx: 0..10 enc r=idx; 11..21 dec r=idx-11 using cell 10-r
  logic [RndW-1:0] rnd, src;
  logic            dec, ready_src;
  blk_t            sel;
  always_comb begin
    dec = idx_q > CntW'(NumRounds);
    rnd = dec ? RndW'(idx_q - CntW'(NumRounds + 1)) : idx_q[RndW-1:0];
    src = dec ? RndW'(NumRounds) - rnd : rnd;
    // a cell holds its key from the cycle where the age reaches its index
    ready_src = (age_q >= src) || (age_q == RndW'(NumRounds));
    sel = cell_key[src];
    if (dec && rnd != '0 && rnd != RndW'(NumRounds)) begin
      sel = inv_mix(cell_key[src]);
    end
    issue = busy_q && ready_src && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      age_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (key_xfer) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        age_q  <= '0;
      end else if (busy_q) begin
        if (age_q != RndW'(NumRounds)) begin
          age_q <= age_q + 1'b1;
        end
        if (issue) begin
          if (idx_q == CntW'(NumOut - 1)) begin
            busy_q <= 1'b0;
          end
          idx_q <= idx_q + 1'b1;
        end
      end
      if (issue) begin
        ovld_q <= 1'b1;
      end else if (rk_xfer) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      orn_q   <= rnd;
      odec_q  <= dec;
      olast_q <= (idx_q == CntW'(NumOut - 1));
      okey_q  <= sel;
    end
  end

  assign rk_valid_o       = ovld_q;
  assign round_number_o   = orn_q;
  assign for_decrypt_o    = odec_q;
  assign round_key_high_o = okey_q[127:64];
  assign round_key_low_o  = okey_q[63:0];
  assign last_o           = olast_q;

  // a stalled result holds its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rk_valid_o && !rk_ready_i |=> rk_valid_o && $stable(round_number_o))
    else $error("stalled round key changed");
  // last only on decrypt round ten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rk_valid_o && last_o |-> for_decrypt_o && round_number_o == 4'(NumRounds))
    else $error("last flag misplaced");
  // an accepted key restarts the sequence at the first round key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_i && key_ready_o |=> busy_q && idx_q == '0)
    else $error("key transfer did not restart the sequence");
endmodule
`default_nettype wire

// ===== src/aks_cell.sv =====
// aks_cell: one round key register of the key chain; computes next key for its neighbor
// depends on aks_pkg
`default_nettype none
module aks_cell import aks_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       load_i,
  input  wire logic [7:0] rcon_i,
  input  blk_t            key_i,
  output blk_t            key_o,
  output blk_t            next_o
);
  blk_t key_q;
  logic [31:0] w0, w1, w2, w3, t;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_i;
    end
  end

  always_comb begin
    t  = {sbox(key_q[23:16]) ^ rcon_i, sbox(key_q[15:8]), sbox(key_q[7:0]),
          sbox(key_q[31:24])};
    w0 = key_q[127:96] ^ t;
    w1 = key_q[95:64] ^ w0;
    w2 = key_q[63:32] ^ w1;
    w3 = key_q[31:0] ^ w2;
  end

  assign key_o  = key_q;
  assign next_o = {w0, w1, w2, w3};
endmodule
`default_nettype wire
